>>> rtl/gtes_pkg.sv
package gtes_pkg;

   // field widths
   localparam int FUNC_W     = 2;
   localparam int THR_W      = 16;
   localparam int SEL_W      = 8;
   localparam int DRIVE_W    = 11;
   localparam int GEAR_OUT_W = 2;
   localparam int CNT_W      = 3;
   localparam int EXPO_W     = 7;
   localparam int LIMIT_W    = 10;
   localparam int MAG_W      = 10;
   localparam int SUM_W      = 17;

   // packed gear tables
   localparam int TABLE_GEARS   = 4;
   localparam int EXPO_TABLE_W  = TABLE_GEARS * EXPO_W;
   localparam int LIMIT_TABLE_W = TABLE_GEARS * LIMIT_W;
   localparam logic [LIMIT_TABLE_W-1:0] LIMIT_TABLE_RESET = 40'd1074791425000;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = LIMIT_TABLE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_GEAR_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPO_TABLE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_TABLE = 2'd2;

   // command codes
   localparam logic [FUNC_W-1:0] FUNC_APPLY = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_UP    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DOWN  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd3;

   // throttle range and table saturation points
   localparam logic signed [THR_W-1:0] THR_HI = 16'sd1000;
   localparam logic signed [THR_W-1:0] THR_LO = -16'sd1000;
   localparam logic signed [DRIVE_W-1:0] DRIVE_HI = 11'sd1000;
   localparam logic signed [DRIVE_W-1:0] DRIVE_LO = -11'sd1000;
   localparam logic [EXPO_W-1:0]  EXPO_FULL  = 7'd100;
   localparam logic [LIMIT_W-1:0] LIMIT_FULL = 10'd1000;

   // shared multiplier and exact reciprocals: floor(n/d) = (n*R) >> S
   localparam int MUL_A_W = 30;
   localparam int MUL_B_W = 31;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam logic [MUL_B_W-1:0] RECIP_1E6 = 31'd1125899907;
   localparam int SHIFT_1E6 = 50;
   localparam logic [MUL_B_W-1:0] RECIP_100 = 31'd167773;
   localparam int SHIFT_100 = 24;
   localparam logic [MUL_B_W-1:0] RECIP_1E3 = 31'd1073742;
   localparam int SHIFT_1E3 = 30;

   typedef struct packed {
      logic [FUNC_W-1:0]       func;
      logic signed [THR_W-1:0] throttle;
      logic [SEL_W-1:0]        gear_select;
   } req_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic [GEAR_OUT_W-1:0]     gear_now;
   } rsp_type;

   // expo of one gear, saturated; gears past the table get zero
   function automatic logic [EXPO_W-1:0] gear_expo(
      input logic [EXPO_TABLE_W-1:0] tbl,
      input logic [CNT_W-1:0]        g
   );
      logic [EXPO_W-1:0] e;
      if (g < CNT_W'(TABLE_GEARS)) begin
         e = tbl[g[1:0]*EXPO_W +: EXPO_W];
      end else begin
         e = '0;
      end
      if (e > EXPO_FULL) begin
         e = EXPO_FULL;
      end
      return e;
   endfunction

   // output limit of one gear, saturated; gears past the table get full scale
   function automatic logic [LIMIT_W-1:0] gear_limit(
      input logic [LIMIT_TABLE_W-1:0] tbl,
      input logic [CNT_W-1:0]         g
   );
      logic [LIMIT_W-1:0] l;
      if (g < CNT_W'(TABLE_GEARS)) begin
         l = tbl[g[1:0]*LIMIT_W +: LIMIT_W];
      end else begin
         l = LIMIT_FULL;
      end
      if (l > LIMIT_FULL) begin
         l = LIMIT_FULL;
      end
      return l;
   endfunction

endpackage

>>> rtl/geared_throttle_expo_shaper.sv
// Geared throttle expo shaper. Each request beat carries one command: apply a
// throttle, shift up, shift down or set the gear; each produces exactly one
// response beat with the shaped drive (zero for gear commands) and the gear in
// effect afterwards. Apply clamps the throttle to -1000..1000, passes zero and
// negative values through, and shapes positive values with the current gear's
// expo curve scaled by its output limit, all with truncating division. Gear
// changes saturate at the ends of the range set by gear_count. A positive apply
// runs its steps through a single registered 30x31 multiplier that also performs
// the divisions by reciprocal; every other command goes straight to the output
// load. One command is in flight at a time and the request side is ready again
// the cycle after the response is loaded; loading waits while a previous
// response still sits untaken in the output register, and a finished response
// may wait there while the next request is taken.
// The configuration port (index 0 gear_count, 1 expo table, 2 limit table) is
// always ready and should be written while idle.
module geared_throttle_expo_shaper #(
   parameter int MAX_GEARS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  gtes_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output gtes_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gtes_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gtes_pkg::CSR_DATA_W-1:0]    csr_data
);
   import gtes_pkg::*;

   localparam int GEAR_W = (MAX_GEARS > 1) ? $clog2(MAX_GEARS) : 1;
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_GEARS);

   localparam int ST_W = 2;
   localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
   localparam logic [ST_W-1:0] ST_CALC = 2'd1;
   localparam logic [ST_W-1:0] ST_LOAD = 2'd2;

   logic [ST_W-1:0]          state_ff, state_in;
   logic [CNT_W-1:0]         gear_count_ff, gear_count_in;
   logic [EXPO_TABLE_W-1:0]  expo_table_ff, expo_table_in;
   logic [LIMIT_TABLE_W-1:0] limit_table_ff, limit_table_in;
   logic [GEAR_W-1:0]        current_gear_ff, current_gear_in;
   rsp_type                  res_ff, res_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     req_fire;
   logic                     csr_fire;
   logic signed [DRIVE_W-1:0] thr_clamp;
   logic                     thr_pos;
   logic [CNT_W-1:0]         count_raw;
   logic [CNT_W-1:0]         count_sat;
   logic                     seq_start;
   logic                     seq_done;
   logic [MAG_W-1:0]         seq_drive;

   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // clamp the throttle into -1000..1000
   always_comb begin
      if (req_data.throttle > THR_HI) begin
         thr_clamp = DRIVE_HI;
      end else if (req_data.throttle < THR_LO) begin
         thr_clamp = DRIVE_LO;
      end else begin
         thr_clamp = DRIVE_W'(req_data.throttle);
      end
      thr_pos = !thr_clamp[DRIVE_W-1] && (thr_clamp != '0);
   end

   // saturate a gear count write to 1..MAX_GEARS
   always_comb begin
      count_raw = csr_data[CNT_W-1:0];
      if (count_raw == '0) begin
         count_sat = CNT_W'(1);
      end else if (count_raw > MAX_COUNT) begin
         count_sat = MAX_COUNT;
      end else begin
         count_sat = count_raw;
      end
   end

   gtes_shape_seq u_shape_seq (
      .clock (clock),
      .reset (reset),
      .start (seq_start),
      .mag   (MAG_W'(thr_clamp)),
      .expo  (gear_expo(expo_table_ff, CNT_W'(current_gear_ff))),
      .limit (gear_limit(limit_table_ff, CNT_W'(current_gear_ff))),
      .done  (seq_done),
      .drive (seq_drive)
   );

   // command sequencer and output register
   always_comb begin
      state_in        = state_ff;
      gear_count_in   = gear_count_ff;
      expo_table_in   = expo_table_ff;
      limit_table_in  = limit_table_ff;
      current_gear_in = current_gear_ff;
      res_in          = res_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff;
      seq_start       = 1'b0;

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_in.drive = '0;
               state_in     = ST_LOAD;
               unique case (req_data.func)
                  FUNC_APPLY: begin
                     if (thr_pos) begin
                        seq_start = 1'b1;
                        state_in  = ST_CALC;
                     end else begin
                        res_in.drive = thr_clamp;
                     end
                  end
                  FUNC_UP: begin
                     if ((CNT_W'(current_gear_ff) + CNT_W'(1)) < gear_count_ff) begin
                        current_gear_in = current_gear_ff + GEAR_W'(1);
                     end
                  end
                  FUNC_DOWN: begin
                     if (current_gear_ff != '0) begin
                        current_gear_in = current_gear_ff - GEAR_W'(1);
                     end
                  end
                  FUNC_SET: begin
                     if (req_data.gear_select < SEL_W'(gear_count_ff)) begin
                        current_gear_in = GEAR_W'(req_data.gear_select);
                     end else begin
                        current_gear_in = GEAR_W'(gear_count_ff - CNT_W'(1));
                     end
                  end
                  default: begin
                     state_in = ST_LOAD;
                  end
               endcase
               res_in.gear_now = GEAR_OUT_W'(current_gear_in);
            end
         end
         ST_CALC: begin
            if (seq_done) begin
               res_in.drive = DRIVE_W'(seq_drive);
               state_in     = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes; a new gear count re-clamps the current gear
      if (csr_fire) begin
         unique case (csr_index)
            CSR_GEAR_COUNT: begin
               gear_count_in = count_sat;
               if (CNT_W'(current_gear_in) >= count_sat) begin
                  current_gear_in = GEAR_W'(count_sat - CNT_W'(1));
               end
            end
            CSR_EXPO_TABLE: begin
               expo_table_in = csr_data[EXPO_TABLE_W-1:0];
            end
            CSR_LIMIT_TABLE: begin
               limit_table_in = csr_data[LIMIT_TABLE_W-1:0];
            end
            default: begin
               gear_count_in = gear_count_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         gear_count_ff   <= CNT_W'(1);
         expo_table_ff   <= '0;
         limit_table_ff  <= LIMIT_TABLE_RESET;
         current_gear_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         gear_count_ff   <= gear_count_in;
         expo_table_ff   <= expo_table_in;
         limit_table_ff  <= limit_table_in;
         current_gear_ff <= current_gear_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   // current gear always lies below the gear count
   a_gear_in_range: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(current_gear_ff) < gear_count_ff)
      else $error("current gear beyond gear count");

   // gear count stays within 1..MAX_GEARS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (gear_count_ff != '0) && (gear_count_ff <= MAX_COUNT))
      else $error("gear count out of range");

   // every delivered drive lies within -1000..1000
   a_drive_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.drive <= DRIVE_HI) && (rsp_ff.drive >= DRIVE_LO)))
      else $error("response drive out of range");
`endif

endmodule

>>> rtl/gtes_mul.sv
module gtes_mul #(
   parameter int A_W = 30,
   parameter int B_W = 31
) (
   input  logic               clock,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic [A_W+B_W-1:0] prod
);

   logic [A_W+B_W-1:0] prod_ff;
   logic [A_W+B_W-1:0] prod_in;

   // multiply, product registered
   assign prod_in = (A_W+B_W)'(a) * (A_W+B_W)'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> rtl/gtes_shape_seq.sv
module gtes_shape_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gtes_pkg::MAG_W-1:0]    mag,
   input  logic [gtes_pkg::EXPO_W-1:0]   expo,
   input  logic [gtes_pkg::LIMIT_W-1:0]  limit,
   output logic                          done,
   output logic [gtes_pkg::MAG_W-1:0]    drive
);
   import gtes_pkg::*;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_SQUARE = 4'd0;
   localparam logic [STEP_W-1:0] STEP_CUBE   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_DIV6   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_EXPO   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_LIN    = 4'd4;
   localparam logic [STEP_W-1:0] STEP_DIV2   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_SCALE  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DIV3   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_DONE   = 4'd8;

   logic                running_ff, running_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [MAG_W-1:0]    x_ff, x_in;
   logic [EXPO_W-1:0]   expo_ff, expo_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [SUM_W-1:0]    t1_ff, t1_in;
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [MUL_P_W-1:0]  prod;

   gtes_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // pick operands for this step; prod holds the previous step's product
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (step_ff)
         STEP_SQUARE: begin
            mul_a = MUL_A_W'(x_ff);
            mul_b = MUL_B_W'(x_ff);
         end
         STEP_CUBE: begin
            mul_a = MUL_A_W'(prod[2*MAG_W-1:0]);
            mul_b = MUL_B_W'(x_ff);
         end
         STEP_DIV6: begin
            mul_a = prod[MUL_A_W-1:0];
            mul_b = RECIP_1E6;
         end
         STEP_EXPO: begin
            mul_a = MUL_A_W'(expo_ff);
            mul_b = MUL_B_W'(prod[SHIFT_1E6 +: MAG_W]);
         end
         STEP_LIN: begin
            mul_a = MUL_A_W'(EXPO_FULL - expo_ff);
            mul_b = MUL_B_W'(x_ff);
         end
         STEP_DIV2: begin
            mul_a = MUL_A_W'(SUM_W'(t1_ff + prod[SUM_W-1:0]));
            mul_b = RECIP_100;
         end
         STEP_SCALE: begin
            mul_a = MUL_A_W'(prod[SHIFT_100 +: MAG_W]);
            mul_b = MUL_B_W'(limit_ff);
         end
         STEP_DIV3: begin
            mul_a = MUL_A_W'(prod[2*MAG_W-1:0]);
            mul_b = RECIP_1E3;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // advance the step counter, hold operands of the item
   always_comb begin
      running_in = running_ff;
      step_in    = step_ff;
      x_in       = x_ff;
      expo_in    = expo_ff;
      limit_in   = limit_ff;
      t1_in      = t1_ff;
      if (start) begin
         running_in = 1'b1;
         step_in    = STEP_SQUARE;
         x_in       = mag;
         expo_in    = expo;
         limit_in   = limit;
      end else if (running_ff) begin
         if (step_ff == STEP_DONE) begin
            running_in = 1'b0;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
      // keep expo * (x^3 / 1e6) while the linear term is formed
      if (running_ff && (step_ff == STEP_LIN)) begin
         t1_in = prod[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         step_ff    <= STEP_SQUARE;
      end else begin
         running_ff <= running_in;
         step_ff    <= step_in;
      end
      x_ff     <= x_in;
      expo_ff  <= expo_in;
      limit_ff <= limit_in;
      t1_ff    <= t1_in;
   end

   assign done  = running_ff && (step_ff == STEP_DONE);
   assign drive = prod[SHIFT_1E3 +: MAG_W];

`ifndef SYNTHESIS
   // scaled result never exceeds the gear's limit
   a_drive_within_limit: assert property (@(posedge clock) disable iff (reset)
      done |-> (drive <= limit_ff))
      else $error("shaped drive exceeds gear limit");
`endif

endmodule

>>> tb/tb.sv
module tb;
   import gtes_pkg::*;

   localparam int MAX_GEARS   = 4;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RAND_PHASES = 7;
   localparam int PHASE_ITEMS = 200;
   // index past the last register; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // Gearbox state mirror plus the queue of response beats still owed.
   class shaper_scoreboard;
      int unsigned                gears_in_use;
      logic [EXPO_TABLE_W-1:0]    expo_table;
      logic [LIMIT_TABLE_W-1:0]   limit_table;
      int unsigned                gear;
      rsp_type                    owed_rsp[$];
      int                         errors;

      function new();
         gears_in_use = 1;
         expo_table   = '0;
         limit_table  = LIMIT_TABLE_RESET;
         gear         = 0;
         errors       = 0;
      endfunction

      // track a register write; a new gear count also re-clamps the gear
      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         int unsigned n;
         case (idx)
            CSR_GEAR_COUNT: begin
               n = value[2:0];
               if (n < 1) n = 1;
               if (n > MAX_GEARS) n = MAX_GEARS;
               gears_in_use = n;
               if (gear >= n) gear = n - 1;
            end
            CSR_EXPO_TABLE: begin
               expo_table = value[EXPO_TABLE_W-1:0];
            end
            CSR_LIMIT_TABLE: begin
               limit_table = value[LIMIT_TABLE_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // clamp, pass brake/reverse through, expo blend and limit scaling for positives
      function int shaped_drive(logic signed [THR_W-1:0] thr);
         int x;
         longint unsigned ux, x3, expo, lim, s;
         x = thr;
         if (x > 1000) x = 1000;
         else if (x < -1000) x = -1000;
         if (x <= 0) return x;
         if (gear < TABLE_GEARS) begin
            expo = expo_table[gear*EXPO_W +: EXPO_W];
            lim  = limit_table[gear*LIMIT_W +: LIMIT_W];
         end else begin
            expo = 0;
            lim  = 1000;
         end
         if (expo > 100) expo = 100;
         if (lim > 1000) lim = 1000;
         ux = x;
         x3 = (ux * ux * ux) / 1000000;
         s  = (expo * x3 + (100 - expo) * ux) / 100;
         return int'((s * lim) / 1000);
      endfunction

      // advance the gearbox by one accepted command and queue its response
      function void note_command(req_type cmd);
         rsp_type beat;
         beat.drive = '0;
         case (cmd.func)
            FUNC_APPLY: begin
               beat.drive = DRIVE_W'(shaped_drive(cmd.throttle));
            end
            FUNC_UP: begin
               if (gear + 1 < gears_in_use) gear++;
            end
            FUNC_DOWN: begin
               if (gear > 0) gear--;
            end
            FUNC_SET: begin
               gear = (cmd.gear_select < gears_in_use) ? cmd.gear_select : gears_in_use - 1;
            end
         endcase
         beat.gear_now = GEAR_OUT_W'(gear);
         owed_rsp.push_back(beat);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (owed_rsp.size() == 0) begin
            $error("unexpected response beat: drive %0d gear_now %0d", got.drive, got.gear_now);
            errors++;
            return;
         end
         want = owed_rsp.pop_front();
         if (got.drive !== want.drive) begin
            $error("drive: expected %0d, actual %0d", want.drive, got.drive);
            errors++;
         end
         if (got.gear_now !== want.gear_now) begin
            $error("gear_now: expected %0d, actual %0d", want.gear_now, got.gear_now);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int                    idle_pct = 0;
   int                    stall_left = 0;
   int                    cycles = 0;
   shaper_scoreboard      sb = new();

   geared_throttle_expo_shaper #(
      .MAX_GEARS(MAX_GEARS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // sample both handshakes at the rising edge; bail out on runaway
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else if (!reset) begin
         if (req_valid && req_ready) sb.note_command(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   // stall the response channel in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
         if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) stall_left = $urandom_range(1, 7);
      end
   end

   // hold one request beat until accepted, with an optional idle burst first
   task automatic send_command(input logic [FUNC_W-1:0] func, input int thr, input int sel);
      int gap;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 7);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid            = 1'b1;
      req_data.func        = func;
      req_data.throttle    = THR_W'(thr);
      req_data.gear_select = SEL_W'(sel);
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait until every owed response has come back
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.owed_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic int pick_throttle();
      logic signed [THR_W-1:0] r;
      case ($urandom_range(0, 9))
         0: begin
            r = THR_W'($urandom);
            return r;
         end
         1: begin
            case ($urandom_range(0, 7))
               0: return -32768;
               1: return 32767;
               2: return -1001;
               3: return -1000;
               4: return 0;
               5: return 1;
               6: return 1000;
               default: return 1001;
            endcase
         end
         2, 3: begin
            return $urandom_range(0, 2200) - 1100;
         end
         default: begin
            return $urandom_range(1, 1000);
         end
      endcase
   endfunction

   // write the registers in turn from a random starting index, with random or extreme contents
   task automatic reconfigure();
      logic [CSR_DATA_W-1:0] value;
      int                    start;
      logic [CSR_IDX_W-1:0]  idx;
      start = $urandom_range(0, 3);
      for (int k = 0; k < 4; k++) begin
         idx   = CSR_IDX_W'((start + k) % 4);
         value = CSR_DATA_W'({$urandom, $urandom});
         case (idx)
            CSR_GEAR_COUNT: begin
               if ($urandom_range(0, 1) == 0) value = '0;
               value[2:0] = 3'($urandom_range(0, 7));
            end
            CSR_EXPO_TABLE: begin
               if ($urandom_range(0, 2) != 0) value[CSR_DATA_W-1:EXPO_TABLE_W] = '0;
               case ($urandom_range(0, 4))
                  0: value[EXPO_TABLE_W-1:0] = '0;
                  1: value[EXPO_TABLE_W-1:0] = '1;
                  2: begin
                  end
                  3: begin
                     for (int g = 0; g < TABLE_GEARS; g++)
                        value[g*EXPO_W +: EXPO_W] = EXPO_W'($urandom_range(0, 100));
                  end
                  default: begin
                     for (int g = 0; g < TABLE_GEARS; g++) begin
                        case ($urandom_range(0, 3))
                           0: value[g*EXPO_W +: EXPO_W] = 7'd0;
                           1: value[g*EXPO_W +: EXPO_W] = EXPO_FULL;
                           2: value[g*EXPO_W +: EXPO_W] = 7'd101;
                           default: value[g*EXPO_W +: EXPO_W] = 7'd127;
                        endcase
                     end
                  end
               endcase
            end
            CSR_LIMIT_TABLE: begin
               case ($urandom_range(0, 4))
                  0: value = '0;
                  1: value = '1;
                  2: begin
                  end
                  3: begin
                     for (int g = 0; g < TABLE_GEARS; g++)
                        value[g*LIMIT_W +: LIMIT_W] = LIMIT_W'($urandom_range(0, 1000));
                  end
                  default: begin
                     for (int g = 0; g < TABLE_GEARS; g++) begin
                        case ($urandom_range(0, 4))
                           0: value[g*LIMIT_W +: LIMIT_W] = 10'd0;
                           1: value[g*LIMIT_W +: LIMIT_W] = 10'd1;
                           2: value[g*LIMIT_W +: LIMIT_W] = LIMIT_FULL;
                           3: value[g*LIMIT_W +: LIMIT_W] = 10'd1001;
                           default: value[g*LIMIT_W +: LIMIT_W] = 10'd1023;
                        endcase
                     end
                  end
               endcase
            end
            default: begin
            end
         endcase
         // skip the spare index most of the time
         if (idx != CSR_SPARE || $urandom_range(0, 2) == 0) write_csr(idx, value);
      end
   endtask

   initial begin
      int r;
      int sel;
      logic [FUNC_W-1:0] func;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset tables, clamping and shift ends with a single gear
      idle_pct = 15;
      send_command(FUNC_APPLY, 0, 0);
      send_command(FUNC_APPLY, 1, 0);
      send_command(FUNC_APPLY, -1, 0);
      send_command(FUNC_APPLY, 1000, 0);
      send_command(FUNC_APPLY, 1001, 0);
      send_command(FUNC_APPLY, 32767, 255);
      send_command(FUNC_APPLY, -1001, 0);
      send_command(FUNC_APPLY, -32768, 0);
      send_command(FUNC_UP, 0, 0);
      send_command(FUNC_DOWN, 0, 0);
      send_command(FUNC_SET, 0, 255);
      settle();

      // directed: zero count, spare index, saturating table fields, full gearbox
      write_csr(CSR_GEAR_COUNT, '0);
      write_csr(CSR_SPARE, '1);
      write_csr(CSR_EXPO_TABLE, {12'hfff, 7'd50, 7'd101, EXPO_FULL, 7'd127});
      write_csr(CSR_LIMIT_TABLE, {10'd0, 10'd1001, LIMIT_FULL, 10'd1023});
      write_csr(CSR_GEAR_COUNT, 40'd7);
      send_command(FUNC_APPLY, 1000, 0);
      send_command(FUNC_APPLY, 999, 0);
      send_command(FUNC_UP, 0, 0);
      send_command(FUNC_APPLY, 500, 0);
      send_command(FUNC_UP, 0, 0);
      send_command(FUNC_APPLY, 1000, 0);
      send_command(FUNC_UP, 0, 0);
      send_command(FUNC_APPLY, 1000, 0);
      send_command(FUNC_UP, 0, 0);
      send_command(FUNC_SET, 0, 200);
      send_command(FUNC_DOWN, 0, 0);
      settle();
      // shrinking the gearbox pulls the current gear down
      write_csr(CSR_GEAR_COUNT, 40'd2);
      send_command(FUNC_APPLY, 777, 3);
      send_command(FUNC_DOWN, 0, 0);
      settle();

      // random phases, each with fresh settings; the last one runs without idling
      for (int p = 0; p < RAND_PHASES; p++) begin
         idle_pct = 0;
         reconfigure();
         case (p % 3)
            0: idle_pct = 10;
            1: idle_pct = 35;
            default: idle_pct = 0;
         endcase
         if (p == RAND_PHASES - 1) idle_pct = 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) func = FUNC_APPLY;
            else if (r < 70) func = FUNC_UP;
            else if (r < 85) func = FUNC_DOWN;
            else func = FUNC_SET;
            sel = ($urandom_range(0, 3) < 3) ? $urandom_range(0, 5) : $urandom_range(0, 255);
            send_command(func, pick_throttle(), sel);
         end
         settle();
      end

      repeat (16) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/gtes_pkg.sv
rtl/gtes_mul.sv
rtl/gtes_shape_seq.sv
rtl/geared_throttle_expo_shaper.sv
tb/tb.sv
